/* rtl/rfae_pkg.sv */
// Package for the register file execute unit: payload types, command codes and sizes.
// Used by every module of the block; depends on nothing.
package rfae_pkg;

    localparam int NUM_REGS = 64;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int IDX_W    = 6;

    typedef enum logic [4:0] {
        CMD_OR = 5'd0, CMD_XOR = 5'd1, CMD_AND = 5'd2, CMD_ADD = 5'd3,
        CMD_SUB = 5'd4, CMD_MUL = 5'd5, CMD_SHL = 5'd6, CMD_SAR = 5'd7,
        CMD_DIV = 5'd8, CMD_MOD = 5'd9, CMD_CMPE = 5'd10, CMD_CMPNE = 5'd11,
        CMD_CMPL = 5'd12, CMD_CMPGE = 5'd13, CMD_CMPLE = 5'd14, CMD_CMPG = 5'd15,
        CMD_LDI = 5'd16
    } t_cmd;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_HALTED = 2'd2;

    typedef struct packed {
        logic [4:0]        cmd;
        logic [IDX_W-1:0]  dst;
        logic [IDX_W-1:0]  src_a;
        logic [IDX_W-1:0]  src_b;
        logic signed [31:0] imm;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic               written;
        logic [1:0]         status;
    } t_out;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // capture the transaction
        logic rd;        // read the source registers
        logic exec;      // compute the ALU result
        logic div_start;
        logic div_step;
        logic wr;        // write back and form the result
    } t_ctl;

    // Datapath to controller status.
    typedef struct packed {
        logic is_div;
        logic div_zero;
        logic div_done;
    } t_sts;

endpackage

/* rtl/rfae_datapath.sv */
// Datapath: register file memory, ALU, multiplier and bit-serial divider.
// Depends on rfae_pkg.
module rfae_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rfae_pkg::t_ctl  i_ctl,
    input  rfae_pkg::t_in   i_item,
    input  logic            i_halted,
    output rfae_pkg::t_sts  o_sts,
    output rfae_pkg::t_out  o_res
);
    import rfae_pkg::*;

    logic [31:0] r_mem [NUM_REGS];
    t_in         r_item;
    logic [31:0] r_a, r_b, r_res;
    logic [REG_AW-1:0] r_clr;
    logic        r_clr_busy;
    // Divider state.
    logic [31:0] r_q, r_rem, r_mb;
    logic [5:0]  r_cnt;
    logic        r_neg_q, r_neg_r;

    logic [REG_AW-1:0] ia, ib, id;
    assign ia = r_item.src_a[REG_AW-1:0];
    assign ib = r_item.src_b[REG_AW-1:0];
    assign id = r_item.dst[REG_AW-1:0];

    // Capture the transaction.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_item <= i_item;
    end

    // Register file with a clearing pass after reset, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_busy <= 1'b1;
        end else if (r_clr_busy) begin
            r_mem[r_clr] <= '0;
            r_clr        <= r_clr + 1'b1;
            if (r_clr == REG_AW'(NUM_REGS - 1)) r_clr_busy <= 1'b0;
        end else if (i_ctl.wr && !i_halted && !o_sts.div_zero && r_item.cmd <= CMD_LDI) begin
            r_mem[id] <= r_res;
        end
        if (i_ctl.rd) begin
            r_a <= r_mem[ia];
            r_b <= r_mem[ib];
        end
    end

    assign o_sts.is_div   = (r_item.cmd == CMD_DIV) || (r_item.cmd == CMD_MOD);
    assign o_sts.div_zero = o_sts.is_div && (r_b == 32'd0);
    assign o_sts.div_done = (r_cnt == 6'd0);

    // Combinational ALU operations.
    logic [31:0] alu;
    logic signed [31:0] sa, sb;
    assign sa = r_a;
    assign sb = r_b;
    always_comb begin
        unique case (r_item.cmd)
            CMD_OR:    alu = r_a | r_b;
            CMD_XOR:   alu = r_a ^ r_b;
            CMD_AND:   alu = r_a & r_b;
            CMD_ADD:   alu = r_a + r_b;
            CMD_SUB:   alu = r_a - r_b;
            CMD_MUL:   alu = 32'(r_a * r_b);
            CMD_SHL:   alu = r_a << r_b[4:0];
            CMD_SAR:   alu = 32'(sa >>> r_b[4:0]);
            CMD_CMPE:  alu = {32{sa == sb}};
            CMD_CMPNE: alu = {32{sa != sb}};
            CMD_CMPL:  alu = {32{sa < sb}};
            CMD_CMPGE: alu = {32{sa >= sb}};
            CMD_CMPLE: alu = {32{sa <= sb}};
            CMD_CMPG:  alu = {32{sa > sb}};
            CMD_LDI:   alu = r_item.imm;
            default:   alu = '0;
        endcase
    end

    // Restoring divider on magnitudes, one quotient bit a cycle.
    logic [32:0] trial;
    assign trial = {r_rem, r_q[31]} - {1'b0, r_mb};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.div_start) begin
            r_q     <= r_a[31] ? -r_a : r_a;
            r_mb    <= r_b[31] ? -r_b : r_b;
            r_rem   <= '0;
            r_cnt   <= 6'd32;
            r_neg_q <= r_a[31] ^ r_b[31];
            r_neg_r <= r_a[31];
        end else if (i_ctl.div_step && r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 1'b1;
            if (!trial[32]) begin
                r_rem <= trial[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_q[31]};
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    // Result register, loaded by exec or at the end of a division.
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_res <= alu;
        end else if (i_ctl.div_step && r_cnt == 6'd0) begin
            if (r_item.cmd == CMD_MOD) r_res <= r_neg_r ? -r_rem : r_rem;
            else                       r_res <= r_neg_q ? -r_q : r_q;
        end
    end

    // Result item formed from the stored result, the halt state and a zero divisor.
    always_comb begin
        o_res = '0;
        if (i_halted) begin
            o_res.status = ST_HALTED;
        end else if (o_sts.div_zero) begin
            o_res.status = ST_DIV0;
        end else if (r_item.cmd <= CMD_LDI) begin
            o_res.value   = r_res;
            o_res.written = 1'b1;
        end
    end
endmodule

/* rtl/rfae_ctrl.sv */
// Controller state machine: sequences read, execute, divide and write back.
// Depends on rfae_pkg.
module rfae_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  rfae_pkg::t_sts  i_sts,
    output rfae_pkg::t_ctl  o_ctl,
    output logic            o_halted
);
    import rfae_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_READ = 7'b0000100,
        S_EXEC  = 7'b0001000, S_DIV  = 7'b0010000, S_WB   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [REG_AW:0] r_clr, n_clr;
    logic r_halted, n_halted;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_halted = r_halted;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_halted = r_halted;
        o_ctl    = '0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == (REG_AW+1)'(NUM_REGS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ctl.load = i_valid;
                if (i_valid) n_state = S_READ;
            end
            S_READ: begin
                o_ctl.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                if (i_sts.is_div && !i_sts.div_zero && !r_halted) begin
                    o_ctl.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_WB;
            end
            S_WB: begin
                o_ctl.wr = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (i_sts.div_zero) n_halted = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_halted <= n_halted;
        end
    end
endmodule

/* rtl/register_file_alu_execute.sv */
// Top level of the register file execute unit.
// Depends on rfae_pkg, rfae_ctrl and rfae_datapath.
//
// Input channel: i_in_valid with o_in_stall carries one operation per
// transaction (command, destination, two sources, immediate).
// Output channel: o_out_valid with i_out_stall carries one result per
// operation: the value written, a written flag and a status code.
// Items are handled one at a time. An ordinary operation presents its result
// after the read, execute and write back states that follow the accepting
// edge, and with no output stall the unit returns to idle and takes the next
// transaction. DIV and MOD add the bit-serial divider state between execute
// and write back, one quotient bit a cycle.
// After reset the register file is cleared, one entry a cycle, during which
// o_in_stall is high. Halt is cleared by reset only.
// While the receiver stalls, the result is held and no new item is taken.
// A zero divisor halts the unit; later items report the halted status.
module register_file_alu_execute (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rfae_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rfae_pkg::t_out o_out_data
);
    import rfae_pkg::*;

    t_ctl ctl;
    t_sts sts;
    logic halted;

    rfae_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_stall(o_in_stall),
        .o_valid(o_out_valid), .i_stall(i_out_stall),
        .i_sts(sts), .o_ctl(ctl), .o_halted(halted)
    );

    rfae_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ctl(ctl), .i_item(i_in_data), .i_halted(halted),
        .o_sts(sts), .o_res(o_out_data)
    );
endmodule

/* tb/sv/register_file_alu_execute_tb.sv */
// Self-checking testbench for the register file execute unit.
// Depends on rfae_pkg and register_file_alu_execute; drives operations and checks results.
module register_file_alu_execute_tb;
    import rfae_pkg::*;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    t_in    i_in_data;
    logic   o_out_valid;
    logic   i_out_stall;
    t_out   o_out_data;

    // Predictor state.
    logic [31:0] shadow_regs [NUM_REGS];
    logic        shadow_halted;
    t_out        pending_results [$];
    int          fail_count;
    bit          quiet_phase;

    // One directed row: operation plus an optional typed-in result.
    typedef struct {
        t_in  op;
        bit   has_known;
        t_out known;
    } t_row;
    t_row directed_rows [$];

    register_file_alu_execute dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Compute the expected result of one operation and update the shadow state.
    function automatic t_out execute_op(t_in op);
        t_out        res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] v;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        bit          wr;
        a   = shadow_regs[op.src_a % NUM_REGS];
        b   = shadow_regs[op.src_b % NUM_REGS];
        v   = '0;
        wr  = 1'b1;
        res = '{value: '0, written: 1'b0, status: ST_OK};
        if (shadow_halted) begin
            res.status = ST_HALTED;
            return res;
        end
        case (op.cmd)
            CMD_OR:    v = a | b;
            CMD_XOR:   v = a ^ b;
            CMD_AND:   v = a & b;
            CMD_ADD:   v = a + b;
            CMD_SUB:   v = a - b;
            CMD_MUL:   v = a * b;
            CMD_SHL:   v = a << b[4:0];
            CMD_SAR:   v = $unsigned($signed(a) >>> b[4:0]);
            CMD_DIV, CMD_MOD: begin
                if (b == '0) begin
                    shadow_halted = 1'b1;
                    res.status    = ST_DIV0;
                    return res;
                end
                // Truncating divide on magnitudes; INT_MIN by -1 wraps naturally.
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q  = ma / mb;
                r  = ma % mb;
                if (op.cmd == CMD_MOD) v = a[31] ? -r : r;
                else                   v = (a[31] ^ b[31]) ? -q : q;
            end
            CMD_CMPE:  v = ($signed(a) == $signed(b)) ? '1 : '0;
            CMD_CMPNE: v = ($signed(a) != $signed(b)) ? '1 : '0;
            CMD_CMPL:  v = ($signed(a) <  $signed(b)) ? '1 : '0;
            CMD_CMPGE: v = ($signed(a) >= $signed(b)) ? '1 : '0;
            CMD_CMPLE: v = ($signed(a) <= $signed(b)) ? '1 : '0;
            CMD_CMPG:  v = ($signed(a) >  $signed(b)) ? '1 : '0;
            CMD_LDI:   v = op.imm;
            default:   wr = 1'b0;
        endcase
        if (wr) begin
            shadow_regs[op.dst % NUM_REGS] = v;
            res.value   = v;
            res.written = 1'b1;
        end
        return res;
    endfunction

    function automatic t_in make_op(logic [4:0] cmd, int d, int a, int b, logic [31:0] imm);
        t_in op;
        op.cmd   = cmd;
        op.dst   = IDX_W'(d);
        op.src_a = IDX_W'(a);
        op.src_b = IDX_W'(b);
        op.imm   = imm;
        return op;
    endfunction

    function automatic void add_row(t_in op, bit has_known, t_out known);
        t_row row;
        row.op        = op;
        row.has_known = has_known;
        row.known     = known;
        directed_rows.push_back(row);
    endfunction

    // Random register index, mostly from a small pool so results feed later operations.
    function automatic int pick_reg();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return $urandom_range(0, 40);
            4:       return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // Random operation; division by zero is kept rare so the run is not halted early.
    function automatic t_in random_op();
        t_in op;
        int  kind;
        op   = make_op(5'($urandom_range(0, 16)), pick_reg(), pick_reg(), pick_reg(),
                       pick_imm());
        kind = $urandom_range(0, 99);
        if (kind < 30) op.cmd = CMD_LDI;
        else if (kind < 33) op.cmd = 5'($urandom_range(17, 31));
        if ((op.cmd == CMD_DIV || op.cmd == CMD_MOD) &&
            shadow_regs[op.src_b % NUM_REGS] == '0 && $urandom_range(0, 99) != 0)
            op.cmd = CMD_LDI;
        return op;
    endfunction

    // Send one transaction, sometimes with a random idle burst ahead of it outside the quiet phase.
    task automatic send_op(t_in op, bit has_known, t_out known);
        t_out predicted;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= op;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = execute_op(op);
        if (has_known && predicted !== known) begin
            $display("%0t: table row disagrees with prediction: expected %h actual %h",
                     $time, known, predicted);
            fail_count++;
        end
        pending_results.push_back(has_known ? known : predicted);
    endtask

    // Output stall: random bursts, none in the quiet phase.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // Result check against the oldest pending expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.value !== want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value,
                             o_out_data.value);
                    fail_count++;
                end
                if (o_out_data.written !== want.written) begin
                    $display("%0t: written expected %b actual %b", $time, want.written,
                             o_out_data.written);
                    fail_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_out_data.status);
                    fail_count++;
                end
            end
        end
    end

    // Main stimulus.
    initial begin
        t_out k;
        t_out none;
        int   wait_cycles;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        fail_count    = 0;
        quiet_phase   = 1'b0;
        shadow_halted = 1'b0;
        none          = '0;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset state, extremes, every operation.
        k = '{value: 32'd0, written: 1'b1, status: ST_OK};
        add_row(make_op(CMD_ADD, 63, 0, 63, '1), 1'b1, k);
        k = '{value: 32'h8000_0000, written: 1'b1, status: ST_OK};
        add_row(make_op(CMD_LDI, 1, 63, 0, 32'h8000_0000), 1'b1, k);
        k = '{value: 32'hFFFF_FFFF, written: 1'b1, status: ST_OK};
        add_row(make_op(CMD_LDI, 2, 0, 0, 32'hFFFF_FFFF), 1'b1, k);
        k = '{value: 32'h7FFF_FFFF, written: 1'b1, status: ST_OK};
        add_row(make_op(CMD_LDI, 3, 0, 0, 32'h7FFF_FFFF), 1'b1, k);
        // Overflowing divide and modulo.
        k = '{value: 32'h8000_0000, written: 1'b1, status: ST_OK};
        add_row(make_op(CMD_DIV, 4, 1, 2, '0), 1'b1, k);
        k = '{value: 32'd0, written: 1'b1, status: ST_OK};
        add_row(make_op(CMD_MOD, 5, 1, 2, '0), 1'b1, k);
        for (int c = CMD_OR; c <= CMD_CMPG; c++)
            add_row(make_op(5'(c), 6 + c % 4, 3, 1, '0), 0, none);
        add_row(make_op(CMD_SAR, 10, 1, 3, '0), 0, none);
        // Unused command does nothing.
        k = '{value: 32'd0, written: 1'b0, status: ST_OK};
        add_row(make_op(5'd31, 11, 1, 2, '1), 1'b1, k);
        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].has_known, directed_rows[i].known);

        // Random part; a zero divisor near the end exercises the halted state.
        for (int n = 0; n < 1300; n++) begin
            if (n == 1200) quiet_phase = 1'b1;
            if (n == 1260) begin
                send_op(make_op(CMD_LDI, 0, 0, 0, '0), 0, none);
                send_op(make_op(CMD_DIV, 9, 3, 0, '0), 0, none);
            end
            send_op(random_op(), 0, none);
        end
        i_in_valid <= 1'b0;

        // Drain, then let the unit idle before the final check.
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("register_file_alu_execute_tb passed");
        else
            $display("register_file_alu_execute_tb failed");
        $finish;
    end

    // Watchdog.
    initial begin
        #600000;
        $display("register_file_alu_execute_tb failed");
        $finish;
    end

endmodule
